// File: hdl/trtm_pkg.sv
// shared types and codes for the ternary rule table match unit
`timescale 1ns / 1ps

package trtm_pkg;

  // fixed field widths
  localparam int DATA_W = 32;
  localparam int PRIO_W = 32;

  // request kinds
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DUP       = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan;
    logic       shift_start;
    logic       shift;
    logic       append;
    logic       count_dec;
    logic       emit;
    logic       emit_match;
    logic [1:0] emit_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       hit;
    logic       exhausted;
    logic       full;
    logic       out_free;
  } stat_t;

endpackage

// File: hdl/trtm_ctrl.sv
// controller state machine for the ternary rule table match unit
`timescale 1ns / 1ps

module trtm_ctrl import trtm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   op_known;
  logic   finish;

  assign op_known = (st.op == OP_INSERT) || (st.op == OP_DELETE) || (st.op == OP_SEARCH);
  assign finish   = st.hit || st.exhausted || !op_known;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (finish && st.out_free) begin
          state_next = (st.op == OP_DELETE && st.hit) ? S_SHIFT : S_IDLE;
        end
      end
      S_SHIFT: begin
        if (st.exhausted) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_SCAN: begin
        if (!finish) begin
          cmd.scan = 1'b1;
        end else if (st.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STAT_NOT_FOUND;
          priority if (st.op == OP_SEARCH) begin
            if (st.hit) begin
              cmd.emit_match  = 1'b1;
              cmd.emit_status = STAT_OK;
            end
          end else if (st.op == OP_INSERT) begin
            if (st.hit) begin
              cmd.emit_status = STAT_DUP;
            end else if (st.full) begin
              cmd.emit_status = STAT_FULL;
            end else begin
              cmd.append      = 1'b1;
              cmd.emit_status = STAT_OK;
            end
          end else if (st.op == OP_DELETE) begin
            if (st.hit) begin
              cmd.shift_start = 1'b1;
              cmd.emit_status = STAT_OK;
            end
          end else begin
            // unused op: report not found, table untouched
            cmd.emit_status = STAT_NOT_FOUND;
          end
        end
      end
      S_SHIFT: begin
        if (st.exhausted) begin
          cmd.count_dec = 1'b1;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: hdl/trtm_dpath.sv
// rule memory, scan pointers, compare logic and result register
`timescale 1ns / 1ps

module trtm_dpath import trtm_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             st,
  input  logic [1:0]        in_op,
  input  logic [DATA_W-1:0] in_pattern,
  input  logic [DATA_W-1:0] in_mask,
  input  logic [PRIO_W-1:0] in_prio,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [PRIO_W-1:0] out_priority,
  output logic [1:0]        out_status
);

  localparam int SW = (KEY_WIDTH < DATA_W) ? KEY_WIDTH : DATA_W;
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int MW = PRIO_W + 2 * SW;

  logic [MW-1:0]     mem [TABLE_DEPTH];
  logic [MW-1:0]     rd_data;
  logic [1:0]        req_op;
  logic [SW-1:0]     req_key;
  logic [SW-1:0]     req_mask;
  logic [SW-1:0]     req_val;
  logic [PRIO_W-1:0] req_prio;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic [CW-1:0]     ptr_dec;
  logic [IW-1:0]     cmp_idx;
  logic              pend;
  logic              issue;
  logic [SW-1:0]     e_val;
  logic [SW-1:0]     e_mask;
  logic [PRIO_W-1:0] e_prio;
  logic              hit_search;
  logic              hit_exact;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [MW-1:0]     wr_data;

  assign e_val  = rd_data[SW-1:0];
  assign e_mask = rd_data[2*SW-1:SW];
  assign e_prio = rd_data[MW-1:2*SW];

  assign hit_search = (e_val == (req_key & ~e_mask));
  assign hit_exact  = (e_val == req_val) && (e_mask == req_mask);

  assign issue   = (cmd.scan || cmd.shift) && (ptr < count);
  assign ptr_dec = ptr - CW'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_data = rd_data;
    if (cmd.append) begin
      wr_en   = 1'b1;
      wr_addr = count[IW-1:0];
      wr_data = {req_prio, req_mask, req_val};
    end else if (cmd.shift && pend) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (issue) rd_data <= mem[ptr[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr  <= '0;
        pend <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr  <= CW'(cmp_idx) + CW'(1);
        pend <= 1'b0;
      end else if (cmd.scan || cmd.shift) begin
        pend <= issue;
        if (issue) ptr <= ptr + CW'(1);
      end
      if (cmd.append) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= in_op;
      req_key  <= in_pattern[SW-1:0];
      req_mask <= in_mask[SW-1:0];
      req_val  <= in_pattern[SW-1:0] & ~in_mask[SW-1:0];
      req_prio <= in_prio;
    end
    // in a shift the pointer runs one ahead of the write slot
    if (issue) cmp_idx <= cmd.shift ? ptr_dec[IW-1:0] : ptr[IW-1:0];
    if (cmd.emit) begin
      out_priority <= cmd.emit_match ? e_prio : '0;
      out_status   <= cmd.emit_status;
    end
  end

  assign st.op        = req_op;
  assign st.hit       = pend && ((req_op == OP_SEARCH) ? hit_search : hit_exact);
  assign st.exhausted = !pend && !(ptr < count);
  assign st.full      = (count == CW'(TABLE_DEPTH));
  assign st.out_free  = !out_valid || out_ready;

endmodule

// File: hdl/ternary_rule_table_match_unit.sv
// top level of the ternary rule table match unit
// result: registered once the scan finds a hit or passes the last entry, at once on an empty
// table or an unused op; a waiting result holds the scan at its end
// a delete hit then moves every later entry up one slot
// one item at a time: a new item is taken only once the scan of the rule memory (one entry
// compared per cycle) and any shift after a delete are done
// reset: synchronous, clears the rule count and the output register; no memory clearing pass
`timescale 1ns / 1ps

module ternary_rule_table_match_unit import trtm_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // pattern [31:0], wildcard_mask [63:32], rule_priority [95:64]
  input  logic [1:0]  s_tuser,   // op [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // match_priority [31:0]
  output logic [1:0]  m_tuser    // status [1:0]
);

  cmd_t  cmd;
  stat_t st;

  // sequencer: accept, scan, report, optional shift
  trtm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // rule memory and compare path; output register lets the next item in while a result waits
  trtm_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_op        (s_tuser),
    .in_pattern   (s_tdata[31:0]),
    .in_mask      (s_tdata[63:32]),
    .in_prio      (s_tdata[95:64]),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_priority (m_tdata),
    .out_status   (m_tuser)
  );

endmodule

// File: hdl/trtm_checker.sv
// port-level assertions for the ternary rule table match unit
`timescale 1ns / 1ps

module trtm_checker import trtm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // only an OK result may carry a nonzero priority
  a_prio_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == 32'd0))
    else $error("nonzero priority on failed request");

  // one request at a time: busy after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a second item while busy");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind ternary_rule_table_match_unit trtm_checker u_chk (.*);
